FILE: src/three_level_fifo_cache_lookup_macros.svh
// Assertion macros shared by the three-level FIFO cache lookup RTL.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef THREE_LEVEL_FIFO_CACHE_LOOKUP_MACROS_SVH
`define THREE_LEVEL_FIFO_CACHE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFLC_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TFLC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

FILE: src/tflc_pkg.sv
// Package for the three-level FIFO cache lookup: sizes, codes, level structs.
// Used by tflc_level and three_level_fifo_cache_lookup; depends on nothing.
`timescale 1ns / 1ps

package tflc_pkg;

	localparam int L1_DEPTH = 4;
	localparam int L2_DEPTH = 8;
	localparam int L3_DEPTH = 8;
	localparam int TAG_BITS = 16;

	localparam int MAX_DEPTH = (L1_DEPTH > L2_DEPTH) ?
		((L1_DEPTH > L3_DEPTH) ? L1_DEPTH : L3_DEPTH) :
		((L2_DEPTH > L3_DEPTH) ? L2_DEPTH : L3_DEPTH);
	localparam int CNT_W = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	localparam int FIELD_TAG_W = 16;
	localparam int LAT_W       = 16;
	localparam int FETCH_W     = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [IDX_W-1:0]    idx_t;

	// Where an access was answered
	typedef enum logic [1:0] {
		LVL_L1  = 2'd0,
		LVL_L2  = 2'd1,
		LVL_L3  = 2'd2,
		LVL_RAM = 2'd3
	} lvl_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_L1_CAP  = 3'd0,
		REG_L2_CAP  = 3'd1,
		REG_L3_CAP  = 3'd2,
		REG_L1_LAT  = 3'd3,
		REG_L2_LAT  = 3'd4,
		REG_L3_LAT  = 3'd5,
		REG_RAM_LAT = 3'd6
	} cfg_reg_t;

	// Control into one FIFO level for the current lookup
	typedef struct packed {
		logic step;
		tag_t tag;
		logic rm_en;
		idx_t rm_pos;
		logic push_en;
		tag_t push_tag;
		cnt_t cap;
	} lvl_ctl_t;

	// Status out of one FIFO level
	typedef struct packed {
		logic hit;
		idx_t hit_pos;
		logic evict;
		tag_t evict_tag;
		cnt_t count;
	} lvl_stat_t;

	// Clamp a capacity register into 1..depth
	function automatic cnt_t eff_cap(input logic [3:0] value, input cnt_t depth);
		logic [7:0] v;
		v = 8'(value);
		if (v == 8'd0) begin
			return cnt_t'(1);
		end else if (v > 8'(depth)) begin
			return depth;
		end
		return cnt_t'(v);
	endfunction

endpackage

FILE: src/tflc_level.sv
// One FIFO-ordered tag level: storage, count, search, removal and append with eviction.
// Depends on tflc_pkg.
`timescale 1ns / 1ps

module tflc_level (
	input  logic               clk,
	input  logic               arst_n,
	input  tflc_pkg::cnt_t     depth,
	input  tflc_pkg::lvl_ctl_t ctl,
	output tflc_pkg::lvl_stat_t stat
);

	tflc_pkg::tag_t st_q [tflc_pkg::MAX_DEPTH];
	tflc_pkg::cnt_t cnt_q;

	tflc_pkg::tag_t mid [tflc_pkg::MAX_DEPTH];
	tflc_pkg::tag_t nxt [tflc_pkg::MAX_DEPTH];
	tflc_pkg::cnt_t cnt_mid;
	tflc_pkg::cnt_t cnt_fin;
	tflc_pkg::cnt_t cnt_nxt;
	logic           hit;
	tflc_pkg::idx_t pos;
	logic           ev;
	logic           put;

	// Search the live entries; the oldest match wins
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = tflc_pkg::MAX_DEPTH - 1; i >= 0; i--) begin
			if (tflc_pkg::cnt_t'(i) < cnt_q && st_q[i] == ctl.tag) begin
				hit = 1'b1;
				pos = tflc_pkg::idx_t'(i);
			end
		end
	end

	// Close the gap left by a removed entry
	always_comb begin
		for (int i = 0; i < tflc_pkg::MAX_DEPTH; i++) begin
			if (ctl.rm_en && tflc_pkg::idx_t'(i) >= ctl.rm_pos && i + 1 < tflc_pkg::MAX_DEPTH) begin
				mid[i] = st_q[i + 1];
			end else begin
				mid[i] = st_q[i];
			end
		end
		cnt_mid = cnt_q - tflc_pkg::cnt_t'(ctl.rm_en);
	end

	// Evict the oldest entry when full, then append at the tail
	always_comb begin
		ev      = ctl.push_en && (cnt_mid != '0) && (cnt_mid >= ctl.cap);
		cnt_fin = cnt_mid - tflc_pkg::cnt_t'(ev);
		put     = ctl.push_en && (cnt_fin < depth);
		for (int i = 0; i < tflc_pkg::MAX_DEPTH; i++) begin
			if (put && tflc_pkg::cnt_t'(i) == cnt_fin) begin
				nxt[i] = ctl.push_tag;
			end else if (ev && i + 1 < tflc_pkg::MAX_DEPTH) begin
				nxt[i] = mid[i + 1];
			end else begin
				nxt[i] = mid[i];
			end
		end
		cnt_nxt = cnt_fin + tflc_pkg::cnt_t'(put);
	end

	// Hold the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_nxt;
		end
	end

	// Advance the tag entries
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			st_q <= nxt;
		end
	end

	assign stat.hit       = hit;
	assign stat.hit_pos   = pos;
	assign stat.evict     = ev;
	assign stat.evict_tag = mid[0];
	assign stat.count     = cnt_q;

endmodule

FILE: src/three_level_fifo_cache_lookup.sv
// Exclusive three-level FIFO tag cache lookup, top level.
// Depends on tflc_pkg, tflc_level and three_level_fifo_cache_lookup_macros.svh.
//
// One block tag per transfer is taken into an input register, searched against
// all three levels in parallel and answered in the result register once it is free
// or draining. One access per cycle is sustained while out_stall is low, the level
// stores updating as each result loads (search, removal and the L1-to-L2-to-L3
// eviction chain all settle between the input and result registers). A new tag is
// taken while a result waits to be collected, until both registers are full.
// Levels start empty after reset with no clearing pass; the user must write the
// configuration through cfg_we/cfg_index/cfg_data while the block is idle; not enforced.
`timescale 1ns / 1ps
`include "three_level_fifo_cache_lookup_macros.svh"

module three_level_fifo_cache_lookup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tflc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tflc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tflc_pkg::FIELD_TAG_W-1:0]    block_tag,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          hit_level,
	output logic [tflc_pkg::LAT_W-1:0]          access_latency,
	output logic [tflc_pkg::FETCH_W-1:0]        ram_fetches,
	output logic                                dropped_valid,
	output logic [tflc_pkg::FIELD_TAG_W-1:0]    dropped_tag
);

	// Configuration registers
	logic [2:0]                 l1_cap_q;
	logic [3:0]                 l2_cap_q;
	logic [3:0]                 l3_cap_q;
	logic [tflc_pkg::LAT_W-1:0] l1_lat_q;
	logic [tflc_pkg::LAT_W-1:0] l2_lat_q;
	logic [tflc_pkg::LAT_W-1:0] l3_lat_q;
	logic [tflc_pkg::LAT_W-1:0] ram_lat_q;

	// Input stage and fetch counter
	logic                         valid_s1;
	tflc_pkg::tag_t               tag_s1;
	logic [tflc_pkg::FETCH_W-1:0] fetch_q;
	logic [tflc_pkg::FETCH_W-1:0] fetch_nxt;

	// Result register
	logic                             out_valid_q;
	tflc_pkg::lvl_t                   hit_level_q;
	logic [tflc_pkg::LAT_W-1:0]       latency_q;
	logic [tflc_pkg::FETCH_W-1:0]     fetches_q;
	logic                             dropped_q;
	logic [tflc_pkg::FIELD_TAG_W-1:0] dropped_tag_q;

	logic                advance;
	logic                take;
	tflc_pkg::lvl_t      lvl;
	logic [tflc_pkg::LAT_W-1:0] lat;
	tflc_pkg::lvl_ctl_t  ctl1, ctl2, ctl3;
	tflc_pkg::lvl_stat_t st1, st2, st3;
	logic                drop;

	// Handshake: the lookup moves on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	// Write configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_cap_q  <= 3'd3;
			l2_cap_q  <= 4'd5;
			l3_cap_q  <= 4'd8;
			l1_lat_q  <= 16'd4;
			l2_lat_q  <= 16'd12;
			l3_lat_q  <= 16'd40;
			ram_lat_q <= 16'd200;
		end else if (cfg_we) begin
			unique case (tflc_pkg::cfg_reg_t'(cfg_index))
				tflc_pkg::REG_L1_CAP:  l1_cap_q  <= cfg_data[2:0];
				tflc_pkg::REG_L2_CAP:  l2_cap_q  <= cfg_data[3:0];
				tflc_pkg::REG_L3_CAP:  l3_cap_q  <= cfg_data[3:0];
				tflc_pkg::REG_L1_LAT:  l1_lat_q  <= cfg_data;
				tflc_pkg::REG_L2_LAT:  l2_lat_q  <= cfg_data;
				tflc_pkg::REG_L3_LAT:  l3_lat_q  <= cfg_data;
				tflc_pkg::REG_RAM_LAT: ram_lat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the accepted tag until it is looked up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tag_s1 <= tflc_pkg::TAG_BITS'(block_tag);
		end
	end

	// Drive the three levels: L1 gets the tag on any miss, evictions cascade down
	always_comb begin
		ctl1.step     = advance;
		ctl1.tag      = tag_s1;
		ctl1.rm_en    = 1'b0;
		ctl1.rm_pos   = '0;
		ctl1.push_en  = !st1.hit;
		ctl1.push_tag = tag_s1;
		ctl1.cap      = tflc_pkg::eff_cap(4'(l1_cap_q), tflc_pkg::cnt_t'(tflc_pkg::L1_DEPTH));

		ctl2.step     = advance;
		ctl2.tag      = tag_s1;
		ctl2.rm_en    = !st1.hit && st2.hit;
		ctl2.rm_pos   = st2.hit_pos;
		ctl2.push_en  = st1.evict;
		ctl2.push_tag = st1.evict_tag;
		ctl2.cap      = tflc_pkg::eff_cap(l2_cap_q, tflc_pkg::cnt_t'(tflc_pkg::L2_DEPTH));

		ctl3.step     = advance;
		ctl3.tag      = tag_s1;
		ctl3.rm_en    = !st1.hit && !st2.hit && st3.hit;
		ctl3.rm_pos   = st3.hit_pos;
		ctl3.push_en  = st2.evict;
		ctl3.push_tag = st2.evict_tag;
		ctl3.cap      = tflc_pkg::eff_cap(l3_cap_q, tflc_pkg::cnt_t'(tflc_pkg::L3_DEPTH));
	end

	tflc_level u_l1 (
		.clk    (clk),
		.arst_n (arst_n),
		.depth  (tflc_pkg::cnt_t'(tflc_pkg::L1_DEPTH)),
		.ctl    (ctl1),
		.stat   (st1)
	);

	tflc_level u_l2 (
		.clk    (clk),
		.arst_n (arst_n),
		.depth  (tflc_pkg::cnt_t'(tflc_pkg::L2_DEPTH)),
		.ctl    (ctl2),
		.stat   (st2)
	);

	tflc_level u_l3 (
		.clk    (clk),
		.arst_n (arst_n),
		.depth  (tflc_pkg::cnt_t'(tflc_pkg::L3_DEPTH)),
		.ctl    (ctl3),
		.stat   (st3)
	);

	// Pick the answering level and its latency
	always_comb begin
		if (st1.hit) begin
			lvl = tflc_pkg::LVL_L1;
			lat = l1_lat_q;
		end else if (st2.hit) begin
			lvl = tflc_pkg::LVL_L2;
			lat = l2_lat_q;
		end else if (st3.hit) begin
			lvl = tflc_pkg::LVL_L3;
			lat = l3_lat_q;
		end else begin
			lvl = tflc_pkg::LVL_RAM;
			lat = ram_lat_q;
		end
		drop = st3.evict;
	end

	// Count main memory fetches, saturating
	always_comb begin
		fetch_nxt = fetch_q;
		if (lvl == tflc_pkg::LVL_RAM && fetch_q != '1) begin
			fetch_nxt = fetch_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_q <= '0;
		end else if (advance) begin
			fetch_q <= fetch_nxt;
		end
	end

	// Load the result register; drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_level_q   <= lvl;
			latency_q     <= lat;
			fetches_q     <= fetch_nxt;
			dropped_q     <= drop;
			dropped_tag_q <= drop ? tflc_pkg::FIELD_TAG_W'(st3.evict_tag) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit_level      = hit_level_q;
	assign access_latency = latency_q;
	assign ram_fetches    = fetches_q;
	assign dropped_valid  = dropped_q;
	assign dropped_tag    = dropped_tag_q;

	// A tag can only leave L3 when something was inserted into L1
	`TFLC_ASSERT_NOW(a_drop_needs_miss, clk, arst_n, out_valid_q && dropped_q,
		hit_level_q != tflc_pkg::LVL_L1, "tag dropped on an L1 hit")

	// An L1 hit leaves every level count unchanged
	`TFLC_ASSERT_NEXT(a_l1_hit_stable, clk, arst_n, advance && st1.hit,
		$stable(st1.count) && $stable(st2.count) && $stable(st3.count),
		"level counts moved on an L1 hit")

	// Each miss to main memory bumps the fetch count by one unless saturated
	`TFLC_ASSERT_NEXT(a_fetch_step, clk, arst_n,
		advance && lvl == tflc_pkg::LVL_RAM && fetch_q != '1,
		fetch_q == $past(fetch_q) + 1'b1, "fetch count did not advance on a miss")

	// Fill counts never exceed the level depths
	`TFLC_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1,
		st1.count <= tflc_pkg::cnt_t'(tflc_pkg::L1_DEPTH) &&
		st2.count <= tflc_pkg::cnt_t'(tflc_pkg::L2_DEPTH) &&
		st3.count <= tflc_pkg::cnt_t'(tflc_pkg::L3_DEPTH), "level count above depth")

endmodule

FILE: bench/tb_three_level_fifo_cache_lookup.sv
// Self-checking bench for three_level_fifo_cache_lookup: directed and random tag streams
// over several capacity and latency settings, checked against an exclusive FIFO predictor.
// Depends on tflc_pkg and the three_level_fifo_cache_lookup RTL.
`timescale 1ns / 1ps

module tb_three_level_fifo_cache_lookup;

	import tflc_pkg::*;

	// Index that maps to no register; writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 225;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [15:0]           value;
	} bench_op_t;

	typedef struct {
		lvl_t        level;
		logic [15:0] latency;
		logic [31:0] fetches;
		logic        drop_v;
		logic [15:0] drop_tag;
	} lookup_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] block_tag = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  hit_level;
	logic [15:0] access_latency;
	logic [31:0] ram_fetches;
	logic        dropped_valid;
	logic [15:0] dropped_tag;

	// Predictor state: one FIFO of tags per level, oldest at the front
	logic [15:0] tag_fifo [3][$];
	logic [3:0]  cap_reg [3] = '{4'd3, 4'd5, 4'd8};
	logic [15:0] lat_reg [4] = '{16'd4, 16'd12, 16'd40, 16'd200};
	logic [31:0] fetch_total = '0;

	lookup_res_t lookup_exp_q [$];
	bench_op_t   pending_ops [$];

	int accepted_cnt = 0;
	int results_seen = 0;
	int error_cnt = 0;
	int in_mode = 1;
	int out_mode = 1;
	int send_wait = 0;
	int stall_left = 0;

	three_level_fifo_cache_lookup u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.block_tag      (block_tag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit_level      (hit_level),
		.access_latency (access_latency),
		.ram_fetches    (ram_fetches),
		.dropped_valid  (dropped_valid),
		.dropped_tag    (dropped_tag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("three_level_fifo_cache_lookup test failed");
		$finish;
	end

	task automatic flag_error(input string msg);
		error_cnt++;
		if (error_cnt <= 40) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	// Pick a wait: none, uniformly drawn, or mostly zero with occasional gaps
	function automatic int draw_wait(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 10);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
		endcase
	endfunction

	function automatic int level_depth(input int lv);
		case (lv)
			0: return L1_DEPTH;
			1: return L2_DEPTH;
			default: return L3_DEPTH;
		endcase
	endfunction

	// Zero acts as one, anything above the depth acts as the depth
	function automatic int eff_capacity(input int lv);
		int v;
		v = int'(cap_reg[lv]);
		if (v == 0) begin
			return 1;
		end
		return (v > level_depth(lv)) ? level_depth(lv) : v;
	endfunction

	function automatic int find_tag(input int lv, input logic [15:0] tag);
		for (int i = 0; i < tag_fifo[lv].size(); i++) begin
			if (tag_fifo[lv][i] == tag) begin
				return i;
			end
		end
		return -1;
	endfunction

	// Append at the tail; push out only the single oldest entry when at or over capacity
	function automatic bit fifo_append(input int lv, input logic [15:0] tag,
			output logic [15:0] old);
		bit ev;
		ev = 1'b0;
		old = '0;
		if (tag_fifo[lv].size() > 0 && (tag_fifo[lv].size() >= eff_capacity(lv) ||
				tag_fifo[lv].size() >= level_depth(lv))) begin
			old = tag_fifo[lv].pop_front();
			ev = 1'b1;
		end
		if (tag_fifo[lv].size() < level_depth(lv)) begin
			tag_fifo[lv].insert(tag_fifo[lv].size(), tag);
		end
		return ev;
	endfunction

	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		case (idx)
			REG_L1_CAP:  cap_reg[0] = {1'b0, value[2:0]};
			REG_L2_CAP:  cap_reg[1] = value[3:0];
			REG_L3_CAP:  cap_reg[2] = value[3:0];
			REG_L1_LAT:  lat_reg[0] = value;
			REG_L2_LAT:  lat_reg[1] = value;
			REG_L3_LAT:  lat_reg[2] = value;
			REG_RAM_LAT: lat_reg[3] = value;
			default: ;
		endcase
	endfunction

	// Search the hierarchy, on an L1 miss move the tag to the L1 tail, and queue the expected result
	task automatic predict_lookup(input logic [15:0] tag);
		lookup_res_t r;
		int pos;
		logic [15:0] ev1, ev2, ev3;
		r.drop_v = 1'b0;
		r.drop_tag = '0;
		if (find_tag(0, tag) >= 0) begin
			r.level = LVL_L1;
			r.latency = lat_reg[0];
		end else begin
			pos = find_tag(1, tag);
			if (pos >= 0) begin
				r.level = LVL_L2;
				r.latency = lat_reg[1];
				tag_fifo[1].delete(pos);
			end else begin
				pos = find_tag(2, tag);
				if (pos >= 0) begin
					r.level = LVL_L3;
					r.latency = lat_reg[2];
					tag_fifo[2].delete(pos);
				end else begin
					r.level = LVL_RAM;
					r.latency = lat_reg[3];
					if (fetch_total != '1) begin
						fetch_total++;
					end
				end
			end
			if (fifo_append(0, tag, ev1)) begin
				if (fifo_append(1, ev1, ev2)) begin
					if (fifo_append(2, ev2, ev3)) begin
						r.drop_v = 1'b1;
						r.drop_tag = ev3;
					end
				end
			end
		end
		r.fetches = fetch_total;
		lookup_exp_q.insert(lookup_exp_q.size(), r);
	endtask

	task automatic add_access(input logic [15:0] tag);
		bench_op_t op;
		op.is_cfg = 1'b0;
		op.idx = '0;
		op.value = tag;
		pending_ops.insert(pending_ops.size(), op);
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		bench_op_t op;
		op.is_cfg = 1'b1;
		op.idx = idx;
		op.value = value;
		pending_ops.insert(pending_ops.size(), op);
	endtask

	// Early phases hit the extremes: minimum, maximum, zero with junk bits, over depth
	function automatic logic [15:0] pick_cap(input int ph, input int legal_max);
		case (ph)
			1: return 16'd1;
			2: return 16'(legal_max);
			3: return 16'hFFF0;
			4: return 16'h000F;
			default: return ($urandom_range(0, 3) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [15:0] pick_latency(input int ph);
		case (ph)
			1, 3: return 16'h0000;
			2, 4: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic program_levels(input int ph);
		add_cfg(REG_L1_CAP, pick_cap(ph, L1_DEPTH));
		add_cfg(REG_L2_CAP, pick_cap(ph, L2_DEPTH));
		add_cfg(REG_L3_CAP, pick_cap(ph, L3_DEPTH));
		add_cfg(REG_L1_LAT, pick_latency(ph));
		add_cfg(REG_L2_LAT, pick_latency(ph));
		add_cfg(REG_L3_LAT, pick_latency(ph));
		add_cfg(REG_RAM_LAT, pick_latency(ph));
		add_cfg(REG_UNUSED, 16'($urandom));
	endtask

	// Build the stimulus plan, then wait for the drain and judge
	initial begin
		logic [15:0] tag_pool [24];
		int pool_len;
		logic [15:0] tag;

		// Reset settings: fill L1, hit L1, hit L2, cascade into L3 until two tags drop,
		// then hit L3, hit L2 and re-fetch the dropped tags from memory
		add_access(16'h0000);
		add_access(16'hFFFF);
		add_access(16'h0000);
		add_access(16'h0001);
		add_access(16'h0002);
		add_access(16'h0000);
		for (int t = 3; t <= 16; t++) begin
			add_access(16'(t));
		end
		add_access(16'h0005);
		add_access(16'h000A);
		add_access(16'h0001);
		add_access(16'hFFFF);

		// Random phases: mostly tags from a small working set so hits reach every level
		for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
			program_levels(ph);
			pool_len = $urandom_range(4, 24);
			foreach (tag_pool[i]) begin
				tag_pool[i] = 16'($urandom);
			end
			tag_pool[0] = 16'h0000;
			tag_pool[1] = 16'hFFFF;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) < 8) begin
					tag = tag_pool[$urandom_range(0, pool_len - 1)];
				end else begin
					tag = 16'($urandom);
				end
				add_access(tag);
			end
		end

		do begin
			@(negedge clk);
		end while (pending_ops.size() != 0 || in_valid || accepted_cnt != results_seen);
		repeat (4) @(negedge clk);
		if (lookup_exp_q.size() != 0) begin
			flag_error($sformatf("%0d expected results never arrived", lookup_exp_q.size()));
		end
		if (error_cnt == 0) begin
			$display("three_level_fifo_cache_lookup test passed");
		end else begin
			$display("three_level_fifo_cache_lookup test failed");
		end
		$finish;
	end

	// Driver: present accesses with random gaps; write registers only when nothing is in flight
	always @(posedge clk or negedge arst_n) begin
		bit took;
		bit drive_v;
		bit drive_we;
		bench_op_t op;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_we <= 1'b0;
			send_wait = 0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				predict_lookup(block_tag);
				accepted_cnt++;
				if (accepted_cnt % 128 == 0) begin
					in_mode = $urandom_range(0, 2);
				end
				send_wait = draw_wait(in_mode);
			end
			drive_v = in_valid && !took;
			drive_we = 1'b0;
			if (!drive_v && pending_ops.size() != 0) begin
				if (pending_ops[0].is_cfg) begin
					if (accepted_cnt == results_seen) begin
						op = pending_ops.pop_front();
						drive_we = 1'b1;
						cfg_index <= op.idx;
						cfg_data <= op.value;
						apply_cfg(op.idx, op.value);
					end
				end else if (send_wait != 0) begin
					send_wait--;
				end else begin
					op = pending_ops.pop_front();
					drive_v = 1'b1;
					block_tag <= op.value;
				end
			end
			in_valid <= drive_v;
			cfg_we <= drive_we;
		end
	end

	// Monitor: collect each result transfer, compare with the oldest prediction, then draw a stall
	always @(posedge clk or negedge arst_n) begin
		lookup_res_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			results_seen <= 0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lookup_exp_q.size() == 0) begin
					flag_error("result transfer with no access outstanding");
				end else begin
					e = lookup_exp_q.pop_front();
					if (hit_level !== e.level) begin
						flag_error($sformatf("hit_level %0d, expected %0d", hit_level, e.level));
					end
					if (access_latency !== e.latency) begin
						flag_error($sformatf("access_latency %0d, expected %0d",
							access_latency, e.latency));
					end
					if (ram_fetches !== e.fetches) begin
						flag_error($sformatf("ram_fetches %0d, expected %0d",
							ram_fetches, e.fetches));
					end
					if (dropped_valid !== e.drop_v) begin
						flag_error($sformatf("dropped_valid %0b, expected %0b",
							dropped_valid, e.drop_v));
					end
					if (dropped_tag !== e.drop_tag) begin
						flag_error($sformatf("dropped_tag %h, expected %h",
							dropped_tag, e.drop_tag));
					end
				end
				results_seen <= results_seen + 1;
				if ((results_seen + 1) % 128 == 0) begin
					out_mode = $urandom_range(0, 2);
				end
				stall_left = draw_wait(out_mode);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

endmodule

FILE: three_level_fifo_cache_lookup.f
+incdir+src
src/tflc_pkg.sv
src/tflc_level.sv
src/three_level_fifo_cache_lookup.sv
bench/tb_three_level_fifo_cache_lookup.sv
